### rtl/ldg_pkg.sv
// Shared constants, types and state encodings of the log depth to gray converter.
`default_nettype none
package ldg_pkg;

    localparam int FRAME_PIXELS  = 262144;
    localparam int LOG_FRAC_BITS = 16;

    localparam int ADDR_W   = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int CNT_W    = $clog2(FRAME_PIXELS + 1);
    localparam int DEPTH_W  = 32;
    localparam int ENTRY_W  = DEPTH_W + 1;
    localparam int CFG_W    = 23;
    localparam int RAW_FRAC = 8;
    localparam int SKY_W    = CFG_W + RAW_FRAC;
    localparam int SRCH_W   = DEPTH_W - 1;
    localparam int ONE_RAW  = 1 << RAW_FRAC;

    localparam logic [CFG_W-1:0]  SKY_MIN   = CFG_W'(100000);
    localparam logic [SRCH_W-1:0] SEARCH_HI = {SRCH_W{1'b1}};

    localparam int LOG_INT_W  = $clog2(DEPTH_W);
    localparam int LOG_W      = LOG_INT_W + LOG_FRAC_BITS;
    localparam int MANT_FRAC  = 30;
    localparam int MANT_W     = MANT_FRAC + 1;
    localparam int NORM_STEPS = 5;
    localparam int LG_STEP_W  = $clog2(LOG_FRAC_BITS);
    localparam int MIN_SPAN_R = ((1 << LOG_FRAC_BITS) + 500) / 1000;
    localparam int MIN_SPAN   = (MIN_SPAN_R == 0) ? 1 : MIN_SPAN_R;

    localparam int GRAY_W    = 8;
    localparam int DIV_N_W   = LOG_W + GRAY_W;
    localparam int DV_STEP_W = $clog2(GRAY_W);

    // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^30
    localparam int      PCT         = 100;
    localparam int      RECIP_SHIFT = 32;
    localparam longint  RECIP       = ((64'd1 << RECIP_SHIFT) + PCT - 1) / PCT;
    localparam int      DIVK_W      = RECIP_SHIFT + CNT_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_VALID = 2'd1;
    localparam logic [1:0] STAT_DROPPED  = 2'd2;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd               kind;
        logic [DEPTH_W-1:0] depth;
        logic               bad;
    } t_req;

    typedef enum logic [4:0] {
        BK_IDLE, BK_CNT, BK_KN, BK_KF, BK_MID, BK_SRCH, BK_CLIPN, BK_CLIPF,
        BK_LOGN, BK_LOGNW, BK_LOGF, BK_LOGFW, BK_PIX_RD, BK_PIX_EV, BK_PIX_LS,
        BK_PIX_LW, BK_PIX_CMP, BK_PIX_DS, BK_PIX_DW, BK_OUT
    } t_bk_state;

    typedef enum logic [1:0] {
        LG_IDLE, LG_NORM, LG_LOAD, LG_SQ
    } t_lg_state;

    typedef enum logic [0:0] {
        DV_IDLE, DV_RUN
    } t_dv_state;

endpackage
`default_nettype wire

### rtl/ldg_log.sv
// Iterative fixed-point log2 unit: leading-one search, then one squaring per fraction bit.
`default_nettype none
module ldg_log (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ldg_pkg::DEPTH_W-1:0] i_x,
    output logic                        o_done,
    output logic [ldg_pkg::LOG_W-1:0]   o_result
);
    import ldg_pkg::*;

    t_lg_state                r_state, n_state;
    logic [DEPTH_W-1:0]       r_m32, n_m32;
    logic [LOG_INT_W-1:0]     r_e, n_e;
    logic [MANT_W-1:0]        r_mant, n_mant;
    logic [LOG_FRAC_BITS-1:0] r_frac, n_frac;
    logic [LG_STEP_W-1:0]     r_step, n_step;
    logic                     r_done, n_done;
    logic [2*MANT_W-1:0]      sq;
    logic [MANT_W:0]          sq_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m32  <= n_m32;
        r_e    <= n_e;
        r_mant <= n_mant;
        r_frac <= n_frac;
        r_step <= n_step;
    end

    always_comb begin
        n_state = r_state;
        n_m32   = r_m32;
        n_e     = r_e;
        n_mant  = r_mant;
        n_frac  = r_frac;
        n_step  = r_step;
        n_done  = 1'b0;
        sq      = r_mant * r_mant;
        sq_top  = sq[MANT_FRAC +: MANT_W+1];
        case (r_state)
            LG_IDLE: begin
                if (i_start) begin
                    n_m32   = i_x;
                    n_e     = LOG_INT_W'(DEPTH_W - 1);
                    n_frac  = '0;
                    n_step  = '0;
                    n_state = LG_NORM;
                end
            end
            LG_NORM: begin
                // binary search for the leading one, halving the shift each step
                case (r_step)
                    LG_STEP_W'(0): if (r_m32[31:16] == '0) begin
                        n_m32 = r_m32 << 16;
                        n_e   = r_e - LOG_INT_W'(16);
                    end
                    LG_STEP_W'(1): if (r_m32[31:24] == '0) begin
                        n_m32 = r_m32 << 8;
                        n_e   = r_e - LOG_INT_W'(8);
                    end
                    LG_STEP_W'(2): if (r_m32[31:28] == '0) begin
                        n_m32 = r_m32 << 4;
                        n_e   = r_e - LOG_INT_W'(4);
                    end
                    LG_STEP_W'(3): if (r_m32[31:30] == '0) begin
                        n_m32 = r_m32 << 2;
                        n_e   = r_e - LOG_INT_W'(2);
                    end
                    LG_STEP_W'(4): if (!r_m32[31]) begin
                        n_m32 = r_m32 << 1;
                        n_e   = r_e - LOG_INT_W'(1);
                    end
                    default: ;
                endcase
                n_step = r_step + LG_STEP_W'(1);
                if (r_step == LG_STEP_W'(NORM_STEPS - 1)) begin
                    n_state = LG_LOAD;
                end
            end
            LG_LOAD: begin
                n_mant  = r_m32[DEPTH_W-1 -: MANT_W];
                n_step  = '0;
                n_state = LG_SQ;
            end
            LG_SQ: begin
                // square, and renormalise when the mantissa reaches two
                if (sq_top[MANT_W]) begin
                    n_mant = sq_top[MANT_W:1];
                    n_frac = {r_frac[LOG_FRAC_BITS-2:0], 1'b1};
                end else begin
                    n_mant = sq_top[MANT_W-1:0];
                    n_frac = {r_frac[LOG_FRAC_BITS-2:0], 1'b0};
                end
                n_step = r_step + LG_STEP_W'(1);
                if (r_step == LG_STEP_W'(LOG_FRAC_BITS - 1)) begin
                    n_done  = 1'b1;
                    n_state = LG_IDLE;
                end
            end
            default: n_state = LG_IDLE;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = {r_e - LOG_INT_W'(RAW_FRAC), r_frac};

endmodule
`default_nettype wire

### rtl/ldg_div.sv
// Restoring divider giving the gray quotient one bit per cycle.
`default_nettype none
module ldg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ldg_pkg::DIV_N_W-1:0] i_num,
    input  logic [ldg_pkg::LOG_W-1:0]   i_den,
    output logic                        o_done,
    output logic [ldg_pkg::GRAY_W-1:0]  o_quot
);
    import ldg_pkg::*;

    t_dv_state            r_state, n_state;
    logic [DIV_N_W-1:0]   r_rem, n_rem;
    logic [DIV_N_W-1:0]   r_dsh, n_dsh;
    logic [GRAY_W-1:0]    r_quot, n_quot;
    logic [DV_STEP_W-1:0] r_step, n_step;
    logic                 r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
        r_step <= n_step;
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_quot  = r_quot;
        n_step  = r_step;
        n_done  = 1'b0;
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_rem   = i_num;
                    n_dsh   = DIV_N_W'(i_den) << (GRAY_W - 1);
                    n_quot  = '0;
                    n_step  = '0;
                    n_state = DV_RUN;
                end
            end
            DV_RUN: begin
                if (r_rem >= r_dsh) begin
                    n_rem  = r_rem - r_dsh;
                    n_quot = {r_quot[GRAY_W-2:0], 1'b1};
                end else begin
                    n_quot = {r_quot[GRAY_W-2:0], 1'b0};
                end
                n_dsh  = r_dsh >> 1;
                n_step = r_step + DV_STEP_W'(1);
                if (r_step == DV_STEP_W'(GRAY_W - 1)) begin
                    n_done  = 1'b1;
                    n_state = DV_IDLE;
                end
            end
            default: n_state = DV_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

### rtl/ldg_front.sv
// Front end: takes requests, tags them as load or read, and queues them for the back end.
`default_nettype none
module ldg_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_cmd,
    input  logic [ldg_pkg::DEPTH_W-1:0] i_depth_value,
    input  logic                        i_depth_bad,
    input  logic                        i_pop,
    output logic                        o_head_valid,
    output ldg_pkg::t_req               o_head
);
    import ldg_pkg::*;

    t_req               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QFILL_W-1:0] r_fill;
    t_req               req_in;
    logic               accept;
    logic               take;

    assign o_full       = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_fill != '0);
    assign accept       = i_push && !o_full;
    assign take         = i_pop && o_head_valid;

    always_comb begin
        req_in.kind  = t_cmd'(i_cmd);
        req_in.depth = i_depth_value;
        req_in.bad   = i_depth_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (accept && !take) begin
                r_fill <= r_fill + QFILL_W'(1);
            end else if (take && !accept) begin
                r_fill <= r_fill - QFILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= req_in;
        end
    end

    assign o_head = r_q[r_rd_ptr];

endmodule
`default_nettype wire

### rtl/ldg_back.sv
// Back end: frame store, clip selection passes, per-pixel log and gray division.
`default_nettype none
module ldg_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ldg_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_head_valid,
    input  ldg_pkg::t_req              i_head,
    output logic                       o_pop_req,
    input  logic                       i_out_pop,
    output logic                       o_out_valid,
    output logic [ldg_pkg::GRAY_W-1:0] o_gray,
    output logic [1:0]                 o_status,
    output logic                       o_last
);
    import ldg_pkg::*;

    function automatic logic f_valid(input logic [ENTRY_W-1:0] e, input logic [SKY_W-1:0] sky);
        f_valid = !e[ENTRY_W-1] && (e[DEPTH_W-1:0] != '0) && !e[DEPTH_W-1]
                  && (e[DEPTH_W-1:0] < {1'b0, sky});
    endfunction

    logic [ENTRY_W-1:0] r_mem [FRAME_PIXELS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_wa, mem_ra;
    logic [ENTRY_W-1:0] mem_wd;

    t_bk_state          r_state, n_state;
    logic [CFG_W-1:0]   r_max_depth, n_max_depth;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_valid_cnt, n_valid_cnt;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]   r_scan_idx, n_scan_idx;
    logic               r_clips, n_clips;
    logic               r_dropped, n_dropped;
    logic               r_rd_vld, n_rd_vld;
    logic               r_out_valid, n_out_valid;

    logic [CNT_W-1:0]   r_acc_n, n_acc_n, r_acc_f, n_acc_f;
    logic [CNT_W-1:0]   r_k_n, n_k_n, r_k_f, n_k_f;
    logic [SRCH_W-1:0]  r_lo_n, n_lo_n, r_hi_n, n_hi_n, r_mid_n, n_mid_n;
    logic [SRCH_W-1:0]  r_lo_f, n_lo_f, r_hi_f, n_hi_f, r_mid_f, n_mid_f;
    logic [DEPTH_W-1:0] r_near, n_near, r_far, n_far, r_pix_d, n_pix_d;
    logic [LOG_W-1:0]   r_log_near, n_log_near, r_log_span, n_log_span;
    logic [LOG_W-1:0]   r_num, n_num, r_diff, n_diff, span;
    logic [GRAY_W-1:0]  r_gray, n_gray, r_out_gray, n_out_gray;
    logic [1:0]         r_out_status, n_out_status;
    logic               r_out_last, n_out_last;

    logic [CFG_W-1:0]   sky_units;
    logic [SKY_W-1:0]   sky;
    logic [DEPTH_W-1:0] d;
    logic               rd_ok, scan_more, scan_end, out_free, last;
    logic [CNT_W-1:0]   load_cnt, next_idx;
    logic [DIVK_W-1:0]  mult_in, prod;
    logic               log_start, log_done, div_start, div_done;
    logic [DEPTH_W-1:0] log_x;
    logic [LOG_W-1:0]   log_res;
    logic [GRAY_W-1:0]  quot;
    logic [DIV_N_W-1:0] div_num;

    ldg_log u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (log_start),
        .i_x      (log_x),
        .o_done   (log_done),
        .o_result (log_res)
    );

    ldg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_log_span),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_max_depth <= SKY_MIN;
            r_count     <= '0;
            r_valid_cnt <= '0;
            r_rd_idx    <= '0;
            r_scan_idx  <= '0;
            r_clips     <= 1'b0;
            r_dropped   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max_depth <= n_max_depth;
            r_count     <= n_count;
            r_valid_cnt <= n_valid_cnt;
            r_rd_idx    <= n_rd_idx;
            r_scan_idx  <= n_scan_idx;
            r_clips     <= n_clips;
            r_dropped   <= n_dropped;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_n      <= n_acc_n;
        r_acc_f      <= n_acc_f;
        r_k_n        <= n_k_n;
        r_k_f        <= n_k_f;
        r_lo_n       <= n_lo_n;
        r_hi_n       <= n_hi_n;
        r_mid_n      <= n_mid_n;
        r_lo_f       <= n_lo_f;
        r_hi_f       <= n_hi_f;
        r_mid_f      <= n_mid_f;
        r_near       <= n_near;
        r_far        <= n_far;
        r_pix_d      <= n_pix_d;
        r_log_near   <= n_log_near;
        r_log_span   <= n_log_span;
        r_num        <= n_num;
        r_diff       <= n_diff;
        r_gray       <= n_gray;
        r_out_gray   <= n_out_gray;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign sky_units = (r_max_depth > SKY_MIN) ? r_max_depth : SKY_MIN;
    assign sky       = {sky_units, {RAW_FRAC{1'b0}}};
    assign d         = r_rd_data[DEPTH_W-1:0];
    assign rd_ok     = r_rd_vld && f_valid(r_rd_data, sky);
    assign scan_more = (r_scan_idx < r_count);
    assign scan_end  = !scan_more && !r_rd_vld;
    assign out_free  = !r_out_valid || i_out_pop;
    assign next_idx  = r_rd_idx + CNT_W'(1);
    assign last      = (next_idx >= r_count);
    assign span      = log_res - r_log_near;
    assign div_num   = {r_diff, {GRAY_W{1'b0}}} - DIV_N_W'(r_diff);
    assign mult_in   = (r_state == BK_KF) ? DIVK_W'(r_valid_cnt) + DIVK_W'(PCT - 1)
                                          : DIVK_W'(r_valid_cnt);
    assign prod      = mult_in * DIVK_W'(RECIP);

    always_comb begin
        n_state      = r_state;
        n_max_depth  = r_max_depth;
        n_count      = r_count;
        n_valid_cnt  = r_valid_cnt;
        n_rd_idx     = r_rd_idx;
        n_scan_idx   = r_scan_idx;
        n_clips      = r_clips;
        n_dropped    = r_dropped;
        n_rd_vld     = 1'b0;
        n_out_valid  = r_out_valid && !i_out_pop;
        n_acc_n      = r_acc_n;
        n_acc_f      = r_acc_f;
        n_k_n        = r_k_n;
        n_k_f        = r_k_f;
        n_lo_n       = r_lo_n;
        n_hi_n       = r_hi_n;
        n_mid_n      = r_mid_n;
        n_lo_f       = r_lo_f;
        n_hi_f       = r_hi_f;
        n_mid_f      = r_mid_f;
        n_near       = r_near;
        n_far        = r_far;
        n_pix_d      = r_pix_d;
        n_log_near   = r_log_near;
        n_log_span   = r_log_span;
        n_num        = r_num;
        n_diff       = r_diff;
        n_gray       = r_gray;
        n_out_gray   = r_out_gray;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        load_cnt     = r_count;
        mem_we       = 1'b0;
        mem_wa       = r_count[ADDR_W-1:0];
        mem_wd       = {i_head.bad, i_head.depth};
        mem_re       = 1'b0;
        mem_ra       = r_scan_idx[ADDR_W-1:0];
        o_pop_req    = 1'b0;
        log_start    = 1'b0;
        log_x        = r_pix_d;
        div_start    = 1'b0;

        if (i_cfg_we) begin
            n_max_depth = i_cfg_wdata;
        end

        case (r_state)
            BK_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.kind == CMD_LOAD) begin
                        o_pop_req = 1'b1;
                        // a load after any readout starts a new frame
                        if (r_clips || r_rd_idx != '0) begin
                            load_cnt    = '0;
                            n_valid_cnt = '0;
                            n_rd_idx    = '0;
                            n_clips     = 1'b0;
                            n_dropped   = 1'b0;
                        end
                        n_count = load_cnt;
                        if (load_cnt >= CNT_W'(FRAME_PIXELS)) begin
                            n_dropped = 1'b1;
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = load_cnt[ADDR_W-1:0];
                            n_count = load_cnt + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        if (out_free) begin
                            o_pop_req    = 1'b1;
                            n_out_valid  = 1'b1;
                            n_out_gray   = '0;
                            n_out_status = STAT_NO_VALID;
                            n_out_last   = 1'b1;
                        end
                    end else if (r_clips) begin
                        n_state = BK_PIX_RD;
                    end else begin
                        n_scan_idx  = '0;
                        n_valid_cnt = '0;
                        n_state     = BK_CNT;
                    end
                end
            end
            BK_CNT: begin
                if (scan_more) begin
                    mem_re     = 1'b1;
                    n_rd_vld   = 1'b1;
                    n_scan_idx = r_scan_idx + CNT_W'(1);
                end
                if (rd_ok) begin
                    n_valid_cnt = r_valid_cnt + CNT_W'(1);
                end
                if (scan_end) begin
                    if (r_valid_cnt == '0) begin
                        n_clips = 1'b1;
                        n_state = BK_PIX_RD;
                    end else begin
                        n_state = BK_KN;
                    end
                end
            end
            BK_KN: begin
                n_k_n   = prod[RECIP_SHIFT +: CNT_W];
                n_state = BK_KF;
            end
            BK_KF: begin
                // floor(99v/100) = v - ceil(v/100)
                n_k_f   = r_valid_cnt - prod[RECIP_SHIFT +: CNT_W];
                n_lo_n  = SRCH_W'(1);
                n_hi_n  = SEARCH_HI;
                n_lo_f  = SRCH_W'(1);
                n_hi_f  = SEARCH_HI;
                n_state = BK_MID;
            end
            BK_MID: begin
                if (r_lo_n >= r_hi_n && r_lo_f >= r_hi_f) begin
                    n_state = BK_CLIPN;
                end else begin
                    n_mid_n    = r_lo_n + ((r_hi_n - r_lo_n) >> 1);
                    n_mid_f    = r_lo_f + ((r_hi_f - r_lo_f) >> 1);
                    n_acc_n    = '0;
                    n_acc_f    = '0;
                    n_scan_idx = '0;
                    n_state    = BK_SRCH;
                end
            end
            BK_SRCH: begin
                if (scan_more) begin
                    mem_re     = 1'b1;
                    n_rd_vld   = 1'b1;
                    n_scan_idx = r_scan_idx + CNT_W'(1);
                end
                if (rd_ok && d <= {1'b0, r_mid_n}) begin
                    n_acc_n = r_acc_n + CNT_W'(1);
                end
                if (rd_ok && d <= {1'b0, r_mid_f}) begin
                    n_acc_f = r_acc_f + CNT_W'(1);
                end
                if (scan_end) begin
                    if (r_lo_n < r_hi_n) begin
                        if (r_acc_n > r_k_n) n_hi_n = r_mid_n;
                        else                 n_lo_n = r_mid_n + SRCH_W'(1);
                    end
                    if (r_lo_f < r_hi_f) begin
                        if (r_acc_f > r_k_f) n_hi_f = r_mid_f;
                        else                 n_lo_f = r_mid_f + SRCH_W'(1);
                    end
                    n_state = BK_MID;
                end
            end
            BK_CLIPN: begin
                n_near  = (r_lo_n < SRCH_W'(ONE_RAW)) ? DEPTH_W'(ONE_RAW) : {1'b0, r_lo_n};
                n_state = BK_CLIPF;
            end
            BK_CLIPF: begin
                n_far   = ({1'b0, r_lo_f} <= r_near) ? r_near + DEPTH_W'(ONE_RAW)
                                                     : {1'b0, r_lo_f};
                n_state = BK_LOGN;
            end
            BK_LOGN: begin
                log_start = 1'b1;
                log_x     = r_near;
                n_state   = BK_LOGNW;
            end
            BK_LOGNW: begin
                if (log_done) begin
                    n_log_near = log_res;
                    n_state    = BK_LOGF;
                end
            end
            BK_LOGF: begin
                log_start = 1'b1;
                log_x     = r_far;
                n_state   = BK_LOGFW;
            end
            BK_LOGFW: begin
                if (log_done) begin
                    n_log_span = (span > LOG_W'(MIN_SPAN)) ? span : LOG_W'(MIN_SPAN);
                    n_clips    = 1'b1;
                    n_state    = BK_PIX_RD;
                end
            end
            BK_PIX_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_rd_idx[ADDR_W-1:0];
                n_state = BK_PIX_EV;
            end
            BK_PIX_EV: begin
                if (r_valid_cnt != '0 && f_valid(r_rd_data, sky)) begin
                    if (d < r_near)     n_pix_d = r_near;
                    else if (d > r_far) n_pix_d = r_far;
                    else                n_pix_d = d;
                    n_state = BK_PIX_LS;
                end else begin
                    n_gray  = '0;
                    n_state = BK_OUT;
                end
            end
            BK_PIX_LS: begin
                log_start = 1'b1;
                n_state   = BK_PIX_LW;
            end
            BK_PIX_LW: begin
                if (log_done) begin
                    n_num   = span;
                    n_state = BK_PIX_CMP;
                end
            end
            BK_PIX_CMP: begin
                if (r_num < r_log_span) begin
                    n_diff  = r_log_span - r_num;
                    n_state = BK_PIX_DS;
                end else begin
                    n_gray  = '0;
                    n_state = BK_OUT;
                end
            end
            BK_PIX_DS: begin
                div_start = 1'b1;
                n_state   = BK_PIX_DW;
            end
            BK_PIX_DW: begin
                if (div_done) begin
                    n_gray  = quot;
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    o_pop_req   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_gray  = r_gray;
                    n_out_last  = last;
                    if (r_valid_cnt == '0)  n_out_status = STAT_NO_VALID;
                    else if (r_dropped)     n_out_status = STAT_DROPPED;
                    else                    n_out_status = STAT_OK;
                    n_rd_idx = next_idx;
                    if (last) begin
                        n_count     = '0;
                        n_valid_cnt = '0;
                        n_rd_idx    = '0;
                        n_clips     = 1'b0;
                        n_dropped   = 1'b0;
                    end
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_gray      = r_out_gray;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

### rtl/log_depth_to_gray.sv
// Top level of the percentile-clipped log depth to gray converter.
//
//  channel   direction  handshake            payload
//  request   in         push / full          i_cmd, i_depth_value, i_depth_bad
//  result    out        empty / pop          o_gray, o_status, o_last_pixel
//  config    in         i_cfg_we             i_cfg_wdata (max_depth)
//
// A load is written to the frame store from the idle state. A read of a pixel uses
// the iterative log2 unit and the bit-serial divider. The first read of a frame adds
// one count pass over the frame store, which has one read port, up to 31 selection
// passes and two log2 runs. Reset clears control state; the frame store is not cleared.
// A four-entry request queue keeps taking requests while the back end stalls on a
// result register that has not been popped.
`default_nettype none
module log_depth_to_gray (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ldg_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_cmd,
    input  logic signed [ldg_pkg::DEPTH_W-1:0] i_depth_value,
    input  logic                             i_depth_bad,
    output logic                             empty,
    input  logic                             pop,
    output logic [ldg_pkg::GRAY_W-1:0]       o_gray,
    output logic [1:0]                       o_status,
    output logic                             o_last_pixel
);
    import ldg_pkg::*;

    logic q_head_valid;
    t_req q_head;
    logic q_pop;
    logic out_valid;

    ldg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_depth_value ($unsigned(i_depth_value)),
        .i_depth_bad   (i_depth_bad),
        .i_pop         (q_pop),
        .o_head_valid  (q_head_valid),
        .o_head        (q_head)
    );

    ldg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop_req    (q_pop),
        .i_out_pop    (pop),
        .o_out_valid  (out_valid),
        .o_gray       (o_gray),
        .o_status     (o_status),
        .o_last       (o_last_pixel)
    );

    assign empty = !out_valid;

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head_valid)
        else $error("back end took a request from an empty queue");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !q_pop) |=> full)
        else $error("queue drained with no request taken");

    a_novalid_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == STAT_NO_VALID) |-> (o_gray == '0))
        else $error("frame without valid depth gave nonzero gray");

endmodule
`default_nettype wire

### bench/ldg_checker.sv
// Watches the request, result and register channels, predicts each gray pixel and compares.
module ldg_checker
    import ldg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic                 i_cmd,
    input  logic [DEPTH_W-1:0]   i_depth_value,
    input  logic                 i_depth_bad,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [GRAY_W-1:0]    i_gray,
    input  logic [1:0]           i_status,
    input  logic                 i_last_pixel,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct {
        logic [GRAY_W-1:0] gray;
        logic [1:0]        status;
        logic              last;
    } t_pixel;

    logic [ENTRY_W-1:0] depth_store [0:FRAME_PIXELS-1];
    int unsigned        sky_cfg;
    int unsigned        n_samples;
    int unsigned        n_valid;
    int unsigned        rd_ptr;
    int unsigned        near_raw;
    int unsigned        far_raw;
    int unsigned        lg_near;
    int unsigned        lg_span;
    bit                 clipped;
    bit                 overflowed;
    t_pixel             pixel_q [$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = pixel_q.size();

    function automatic longint unsigned sky_limit();
        longint unsigned s;
        s = (sky_cfg > 100000) ? sky_cfg : 100000;
        return s << RAW_FRAC;
    endfunction

    function automatic bit depth_ok(logic [ENTRY_W-1:0] ent, longint unsigned sky);
        logic [DEPTH_W-1:0] d;
        d = ent[DEPTH_W-1:0];
        if (ent[DEPTH_W]) return 0;
        if (d == 0 || d[DEPTH_W-1]) return 0;
        return longint'(d) < sky;
    endfunction

    // log2 in world units: leading-one position, then fraction by repeated squaring
    function automatic int unsigned log2_depth(longint unsigned x);
        int unsigned     ex;
        int unsigned     frac;
        longint unsigned m;
        longint unsigned t;
        ex = 0;
        frac = 0;
        t = x;
        while (t > 1) begin
            t = t >> 1;
            ex++;
        end
        m = (ex <= 30) ? (x << (30 - ex)) : (x >> (ex - 30));
        for (int i = 0; i < LOG_FRAC_BITS; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return ((ex - RAW_FRAC) << LOG_FRAC_BITS) | frac;
    endfunction

    // smallest depth with more than rank valid depths at or below it
    function automatic int unsigned depth_of_rank(int unsigned rank, longint unsigned sky);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned cnt;
        lo = 1;
        hi = 32'h7FFF_FFFF;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            cnt = 0;
            for (int unsigned i = 0; i < n_samples; i++)
                if (depth_ok(depth_store[i], sky) && depth_store[i][DEPTH_W-1:0] <= mid)
                    cnt++;
            if (cnt > rank) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic void new_frame();
        n_samples = 0;
        n_valid = 0;
        rd_ptr = 0;
        clipped = 0;
        overflowed = 0;
    endfunction

    function automatic void find_clips();
        longint unsigned sky;
        int unsigned     v;
        int unsigned     lf;
        int unsigned     span;
        sky = sky_limit();
        v = 0;
        for (int unsigned i = 0; i < n_samples; i++)
            if (depth_ok(depth_store[i], sky)) v++;
        n_valid = v;
        clipped = 1;
        if (v == 0) return;
        near_raw = depth_of_rank(v / 100, sky);
        far_raw = depth_of_rank(int'((longint'(v) * 99) / 100), sky);
        if (near_raw < ONE_RAW) near_raw = ONE_RAW;
        if (far_raw <= near_raw) far_raw = near_raw + ONE_RAW;
        lg_near = log2_depth(near_raw);
        lf = log2_depth(far_raw);
        span = lf - lg_near;
        lg_span = (span > MIN_SPAN) ? span : MIN_SPAN;
    endfunction

    function automatic void take_request(logic cmd, logic [DEPTH_W-1:0] dv, logic bad);
        t_pixel          px;
        logic [ENTRY_W-1:0] ent;
        int unsigned     d;
        int unsigned     num;
        if (t_cmd'(cmd) == CMD_LOAD) begin
            if (clipped || rd_ptr != 0) new_frame();
            if (n_samples >= FRAME_PIXELS) begin
                overflowed = 1;
                return;
            end
            depth_store[n_samples] = {bad, dv};
            n_samples++;
            return;
        end
        px.gray = '0;
        if (n_samples == 0) begin
            px.status = STAT_NO_VALID;
            px.last = 1;
            pixel_q.push_back(px);
            return;
        end
        if (!clipped) find_clips();
        ent = depth_store[rd_ptr];
        if (n_valid == 0) px.status = STAT_NO_VALID;
        else px.status = overflowed ? STAT_DROPPED : STAT_OK;
        if (n_valid != 0 && depth_ok(ent, sky_limit())) begin
            d = ent[DEPTH_W-1:0];
            if (d < near_raw) d = near_raw;
            if (d > far_raw) d = far_raw;
            num = log2_depth(d) - lg_near;
            if (num < lg_span)
                px.gray = GRAY_W'((longint'(255) * (lg_span - num)) / lg_span);
        end
        rd_ptr++;
        px.last = rd_ptr >= n_samples;
        if (px.last) new_frame();
        pixel_q.push_back(px);
    endfunction

    function automatic void check_pixel();
        t_pixel want;
        if (pixel_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("%0t: unexpected pixel gray=%0d status=%0d last=%0b",
                         $realtime, i_gray, i_status, i_last_pixel);
            return;
        end
        want = pixel_q.pop_front();
        if (want.gray !== i_gray || want.status !== i_status || want.last !== i_last_pixel)
        begin
            fails++;
            if (fails <= 10)
                $display("%0t: pixel mismatch exp gray=%0d status=%0d last=%0b, got %0d %0d %0b",
                         $realtime, want.gray, want.status, want.last,
                         i_gray, i_status, i_last_pixel);
        end
    endfunction

    initial begin
        fails = 0;
        sky_cfg = 100000;
        new_frame();
        near_raw = 0;
        far_raw = 0;
        lg_near = 0;
        lg_span = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sky_cfg = 100000;
            new_frame();
            pixel_q.delete();
        end else begin
            if (i_cfg_we) sky_cfg = i_cfg_wdata;
            if (i_push && !i_full) take_request(i_cmd, i_depth_value, i_depth_bad);
            if (i_pop && !i_empty) check_pixel();
        end
    end

endmodule

### bench/log_depth_to_gray_test.sv
// Top of the converter testbench: clock, reset, request and register stimulus, verdict.
module log_depth_to_gray_test;
    import ldg_pkg::*;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_we = 0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 push = 0;
    logic                 full;
    logic                 i_cmd = CMD_LOAD;
    logic [DEPTH_W-1:0]   i_depth_value = '0;
    logic                 i_depth_bad = 0;
    logic                 empty;
    logic                 pop = 0;
    logic [GRAY_W-1:0]    o_gray;
    logic [1:0]           o_status;
    logic                 o_last_pixel;
    int                   fail_count;
    int                   pending;

    int                   send_idle;
    int                   recv_idle = 0;
    int                   hold_req = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;
    int                   n_loads = 0;
    int                   n_reads = 0;
    int                   n_frames = 0;
    int                   n_cfg = 0;
    logic [DEPTH_W-1:0]   prev_depth = 32'd25600;

    log_depth_to_gray dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .push(push), .full(full), .i_cmd(i_cmd), .i_depth_value(i_depth_value),
        .i_depth_bad(i_depth_bad), .empty(empty), .pop(pop), .o_gray(o_gray),
        .o_status(o_status), .o_last_pixel(o_last_pixel)
    );

    ldg_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_push(push), .i_full(full), .i_cmd(i_cmd), .i_depth_value(i_depth_value),
        .i_depth_bad(i_depth_bad), .i_empty(empty), .i_pop(pop), .i_gray(o_gray),
        .i_status(o_status), .i_last_pixel(o_last_pixel),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // result side: random stalls, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            pop <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // called at a clock edge; returns at the edge that accepts the request
    task automatic send_request(t_cmd cmd, logic [DEPTH_W-1:0] dv, logic bad);
        while ($urandom_range(99) < send_idle) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_cmd <= cmd;
        i_depth_value <= dv;
        i_depth_bad <= bad;
        do @(posedge i_clk); while (full);
        if (cmd == CMD_LOAD) n_loads++;
        else n_reads++;
    endtask

    task automatic load(logic [DEPTH_W-1:0] dv, logic bad);
        send_request(CMD_LOAD, dv, bad);
    endtask

    task automatic read_pixels(int n);
        for (int i = 0; i < n; i++) send_request(CMD_READ, $urandom, $urandom_range(1));
    endtask

    // drain results, then let queued loads reach the back end
    task automatic settle();
        push <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_sky(logic [CFG_W-1:0] v);
        settle();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        n_cfg++;
    endtask

    function automatic logic [DEPTH_W-1:0] pick_depth();
        logic [DEPTH_W-1:0] d;
        case ($urandom_range(9))
            0, 1, 2, 3: d = DEPTH_W'($urandom_range(1, 1 << 23)) << $urandom_range(0, 8);
            4, 5:       d = $urandom;
            6:          d = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
            7:          d = 32'd25600000 + $urandom_range(4) - 2;
            8:          d = $urandom_range(1, 255);
            default:    d = prev_depth;
        endcase
        prev_depth = d;
        return d;
    endfunction

    task automatic random_frame();
        int n;
        int r;
        n = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 24);
        case ($urandom_range(9))
            0:       r = $urandom_range(0, n - 1);
            1:       r = n + 1;
            default: r = n;
        endcase
        for (int i = 0; i < n; i++) load(pick_depth(), $urandom_range(9) == 0);
        read_pixels(r);
        n_frames++;
    endtask

    initial begin
        send_idle = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // extremes, sky edge, flagged depth and depths below one unit
        load(32'd0, 0);
        load(32'hFFFF_FFFF, 0);
        load(32'h8000_0000, 0);
        load(32'h7FFF_FFFF, 0);
        load(32'd1, 0);
        load(32'd25599999, 0);
        load(32'd25600000, 0);
        load(32'd51200, 1);
        load(32'd256, 0);
        load(32'd512, 0);
        read_pixels(10);
        // empty frame, then a frame with nothing valid
        read_pixels(1);
        load(32'd1000, 1);
        read_pixels(1);
        // one valid depth: far is pushed one unit above near
        load(32'd3000, 0);
        read_pixels(1);
        // load during readout abandons the frame
        load(32'd700, 0);
        load(32'd90000, 0);
        read_pixels(1);
        load(32'd5000, 0);
        load(32'd40000, 0);
        read_pixels(2);
        n_frames += 5;

        // sky raised in the middle of a readout
        load(32'd1000, 0);
        load(32'h7000_0000, 0);
        load(32'd2000000, 0);
        read_pixels(1);
        write_sky(23'h7FFFFF);
        read_pixels(2);
        n_frames++;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_idle <= 0;  end
                1: begin send_idle = 64; recv_idle <= 0;  end
                2: begin send_idle = 0;  recv_idle <= 64; end
                default: begin send_idle = 38; recv_idle <= 38; end
            endcase
            if (ph == 1) begin
                // fill the block while results are held back
                for (int i = 0; i < 20; i++) load(pick_depth(), 0);
                hold_req <= hold_req + 1;
                read_pixels(20);
                n_frames++;
            end
            while (n_loads + n_reads < 130 * (ph + 1) + 40) random_frame();
            case (ph)
                0: write_sky(23'd0);
                1: write_sky(23'd100000);
                2: write_sky(CFG_W'($urandom_range(100001, 8388607)));
                default: ;
            endcase
        end

        settle();
        $display("Sent %0d loads and %0d reads in %0d frames under %0d register settings,",
                 n_loads, n_reads, n_frames, n_cfg + 1);
        $display("with four sender/receiver stall mixes and one long result hold-off.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
